// ===== design/cpid_pkg.sv =====
// Package for the cascaded PID controller: shared widths, the request
// struct of the serial multiplier and the register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cpid_pkg;

  // Serial multiplier geometry: a multiplicand of up to 58 bits times a
  // 24-bit gain, one 4-bit digit of the gain per cycle.
  localparam int MC_W    = 58;
  localparam int MP_W    = 24;
  localparam int DIGIT_W = 4;
  localparam int PROD_W  = MC_W + MP_W;
  localparam int STEPS   = MP_W / DIGIT_W;
  localparam int CNT_W   = $clog2(STEPS + 1);

  localparam int DATA_W = 32;
  localparam int ERR_W  = 33;
  localparam int DIFF_W = 34;
  localparam int CFG_W  = 24;
  localparam int IDX_W  = 3;

  // Register indexes of the configuration port.
  localparam logic [IDX_W-1:0] REG_OUTER_KP    = 3'd0;
  localparam logic [IDX_W-1:0] REG_OUTER_KI    = 3'd1;
  localparam logic [IDX_W-1:0] REG_OUTER_KD    = 3'd2;
  localparam logic [IDX_W-1:0] REG_INNER_KP    = 3'd3;
  localparam logic [IDX_W-1:0] REG_INNER_KI    = 3'd4;
  localparam logic [IDX_W-1:0] REG_INNER_KD    = 3'd5;
  localparam logic [IDX_W-1:0] REG_STEP_PERIOD = 3'd6;
  localparam logic [IDX_W-1:0] REG_STEP_RATE   = 3'd7;

  // Input kinds.
  localparam logic KIND_STEP  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // Request from the sequencer to the serial multiplier.
  typedef struct packed {
    logic              start;
    logic [MC_W-1:0]   mcand;
    logic [MP_W-1:0]   mplier;
  } mul_req_t;

endpackage
`default_nettype wire

// ===== design/cascade_pid_controller.sv =====
// Top level of the cascaded PID controller: stream ports, configuration
// registers, loop state and the sequencer. Depends on cpid_pkg, cpid_mul.
//
// Usage: write the gains, step_period and step_rate through the write
// port while the block is idle. Each input beat on the slave stream is
// either a control step (tuser = 0) or a clear (tuser = 1). Every input
// beat gives exactly one output beat carrying drive and inner_setpoint.
// A step runs the outer loop and then the inner loop. Each loop does five
// multiplies on one shared digit-serial multiplier, each started in
// S_MSTART and awaited in S_MWAIT, then one integrator update and one
// output sum. A clear zeroes the loop state and goes straight to S_OUT.
// S_OUT loads the output register and returns to idle. One item is
// worked on at a time: s_axis_tready is high only while the sequencer is
// idle, and it may rise while a finished result still waits in the output
// register. If the receiver stalls, the result holds on the master stream
// and a following item stalls at its end until the register frees.
// Reset zeroes the configuration, both integrators, previous errors and
// the output valid flag, and returns the sequencer to idle.
`timescale 1ns / 1ps
`default_nettype none
module cascade_pid_controller #(
  parameter int INTEGRATOR_WIDTH = 48
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Fields from bit 0: target, outer_measured, inner_measured.
  input  wire logic [95:0] s_axis_tdata,
  // Fields from bit 0: kind.
  input  wire logic        s_axis_tuser,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // Fields from bit 0: drive, inner_setpoint.
  output logic [63:0]      m_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i
);
  import cpid_pkg::*;

  localparam int IW  = INTEGRATOR_WIDTH;
  localparam int IXW = ((IW > 44) ? IW : 44) + 1;
  localparam int SW  = ((IW > 59) ? IW : 59) + 2;

  // Multiplies of one loop, in the order they run.
  localparam logic [2:0] OP_P_GAIN   = 3'd0;
  localparam logic [2:0] OP_I_GAIN   = 3'd1;
  localparam logic [2:0] OP_I_PERIOD = 3'd2;
  localparam logic [2:0] OP_D_GAIN   = 3'd3;
  localparam logic [2:0] OP_D_RATE   = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE, S_ERR, S_MSTART, S_MWAIT, S_INT, S_SUM, S_OUT
  } state_e;

  state_e            state_q;
  logic              loop_q;
  logic [2:0]        op_q;
  logic [CFG_W-1:0]  cfg_q [8];
  logic [DATA_W-1:0] tgt_q, om_q, im_q;
  logic [ERR_W-1:0]  err_q;
  logic [ERR_W-1:0]  mage_q;
  logic [DIFF_W-1:0] magd_q;
  logic              nege_q, negd_q;
  logic [40:0]       p_q;
  logic [41:0]       inc_q;
  logic [57:0]       d_q;
  logic [MC_W-1:0]   t_q;
  logic [IW-1:0]     oi_q, ii_q;
  logic [ERR_W-1:0]  oe_q, ie_q;
  logic [DATA_W-1:0] sp_q, drv_q;
  logic [63:0]       out_q;
  logic              out_valid_q;

  mul_req_t          req;
  logic              mul_done;
  logic [PROD_W-1:0] prod;

  logic [ERR_W-1:0]  err_c, last_c;
  logic [DIFF_W-1:0] diff_c;
  logic [IW-1:0]     integ_c;
  logic signed [IXW-1:0] isum_c, imax_c, imin_c;
  logic [IW-1:0]     inew_c;
  logic signed [SW-1:0] lsum_c, pmax_c, nmin_c;
  logic [DATA_W-1:0] lout_c;

  cpid_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .done_o (mul_done),
    .prod_o (prod)
  );

  // Error of the current loop and its change since the last step.
  always_comb begin
    if (loop_q) begin
      err_c  = {sp_q[DATA_W-1], sp_q} - {im_q[DATA_W-1], im_q};
      last_c = ie_q;
    end else begin
      err_c  = {tgt_q[DATA_W-1], tgt_q} - {om_q[DATA_W-1], om_q};
      last_c = oe_q;
    end
    diff_c = {err_c[ERR_W-1], err_c} - {last_c[ERR_W-1], last_c};
  end

  // Operand selection for the multiplier, by operation and loop.
  always_comb begin
    req.start  = (state_q == S_MSTART);
    req.mcand  = {{(MC_W-ERR_W){1'b0}}, mage_q};
    req.mplier = cfg_q[loop_q ? REG_INNER_KP : REG_OUTER_KP];
    case (op_q)
      OP_P_GAIN: req.mplier = cfg_q[loop_q ? REG_INNER_KP : REG_OUTER_KP];
      OP_I_GAIN: req.mplier = cfg_q[loop_q ? REG_INNER_KI : REG_OUTER_KI];
      OP_I_PERIOD: begin
        req.mcand  = t_q;
        req.mplier = cfg_q[REG_STEP_PERIOD];
      end
      OP_D_GAIN: begin
        req.mcand  = {{(MC_W-DIFF_W){1'b0}}, magd_q};
        req.mplier = cfg_q[loop_q ? REG_INNER_KD : REG_OUTER_KD];
      end
      OP_D_RATE: begin
        req.mcand  = t_q;
        req.mplier = cfg_q[REG_STEP_RATE];
      end
      default: ;
    endcase
  end

  // Saturating integrator update.
  always_comb begin
    integ_c = loop_q ? ii_q : oi_q;
    imax_c  = IXW'({1'b0, {(IW-1){1'b1}}});
    imin_c  = -imax_c - IXW'(1);
    isum_c  = $signed({{(IXW-IW){integ_c[IW-1]}}, integ_c})
            + (nege_q ? -$signed({{(IXW-42){1'b0}}, inc_q})
                      :  $signed({{(IXW-42){1'b0}}, inc_q}));
    if (isum_c > imax_c)      inew_c = imax_c[IW-1:0];
    else if (isum_c < imin_c) inew_c = imin_c[IW-1:0];
    else                      inew_c = isum_c[IW-1:0];
  end

  // Loop output: P + D + I, saturated to 32 bits.
  always_comb begin
    pmax_c = SW'(32'h7FFF_FFFF);
    nmin_c = -pmax_c - SW'(1);
    lsum_c = (nege_q ? -$signed({{(SW-41){1'b0}}, p_q}) : $signed({{(SW-41){1'b0}}, p_q}))
           + (negd_q ? -$signed({{(SW-58){1'b0}}, d_q}) : $signed({{(SW-58){1'b0}}, d_q}))
           + $signed({{(SW-IW){integ_c[IW-1]}}, integ_c});
    if (lsum_c > pmax_c)      lout_c = 32'h7FFF_FFFF;
    else if (lsum_c < nmin_c) lout_c = 32'h8000_0000;
    else                      lout_c = lsum_c[DATA_W-1:0];
  end

  // Sequencer, loop state, configuration and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      loop_q      <= 1'b0;
      op_q        <= '0;
      for (int k = 0; k < 8; k++) cfg_q[k] <= '0;
      oi_q        <= '0;
      ii_q        <= '0;
      oe_q        <= '0;
      ie_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) cfg_q[cfg_index_i] <= cfg_data_i;
      // A taken beat frees the register unless a new result loads it now.
      if (out_valid_q && m_axis_tready && (state_q != S_OUT)) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            tgt_q  <= s_axis_tdata[31:0];
            om_q   <= s_axis_tdata[63:32];
            im_q   <= s_axis_tdata[95:64];
            loop_q <= 1'b0;
            if (s_axis_tuser == KIND_CLEAR) begin
              oi_q    <= '0;
              ii_q    <= '0;
              oe_q    <= '0;
              ie_q    <= '0;
              sp_q    <= '0;
              drv_q   <= '0;
              state_q <= S_OUT;
            end else begin
              state_q <= S_ERR;
            end
          end
        end
        S_ERR: begin
          err_q   <= err_c;
          nege_q  <= err_c[ERR_W-1];
          mage_q  <= err_c[ERR_W-1] ? -err_c : err_c;
          negd_q  <= diff_c[DIFF_W-1];
          magd_q  <= diff_c[DIFF_W-1] ? -diff_c : diff_c;
          op_q    <= OP_P_GAIN;
          state_q <= S_MSTART;
        end
        S_MSTART: state_q <= S_MWAIT;
        S_MWAIT: begin
          if (mul_done) begin
            case (op_q)
              OP_P_GAIN:   p_q   <= prod[56:16];
              OP_I_PERIOD: inc_q <= prod[81:40];
              OP_D_RATE:   d_q   <= prod[81:24];
              default:     t_q   <= prod[MC_W-1:0];
            endcase
            if (op_q == OP_D_RATE) begin
              state_q <= S_INT;
            end else begin
              op_q    <= op_q + 3'd1;
              state_q <= S_MSTART;
            end
          end
        end
        S_INT: begin
          if (loop_q) begin
            ii_q <= inew_c;
            ie_q <= err_q;
          end else begin
            oi_q <= inew_c;
            oe_q <= err_q;
          end
          state_q <= S_SUM;
        end
        S_SUM: begin
          if (loop_q) begin
            drv_q   <= lout_c;
            state_q <= S_OUT;
          end else begin
            sp_q    <= lout_c;
            loop_q  <= 1'b1;
            state_q <= S_ERR;
          end
        end
        S_OUT: begin
          if (!out_valid_q || m_axis_tready) begin
            out_q       <= {sp_q, drv_q};
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule
`default_nettype wire

// ===== design/cpid_mul.sv =====
// Digit-serial unsigned multiplier: retires one 4-bit digit of the
// multiplier per cycle through a shifting product register.
// Depends on cpid_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cpid_mul (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire cpid_pkg::mul_req_t       req_i,
  output logic                          done_o,
  output logic [cpid_pkg::PROD_W-1:0]   prod_o
);
  import cpid_pkg::*;

  logic [PROD_W-1:0]    prod_q, prod_d;
  logic [MC_W-1:0]      mcand_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 done_q;
  logic [MC_W+DIGIT_W-1:0] sum;

  // Add the multiplicand times the lowest digit to the upper half, then
  // shift the whole product register down by one digit.
  always_comb begin
    sum = {{DIGIT_W{1'b0}}, prod_q[PROD_W-1:MP_W]}
        + ({{DIGIT_W{1'b0}}, mcand_q} * {{MC_W{1'b0}}, prod_q[DIGIT_W-1:0]});
    prod_d = {sum, prod_q[MP_W-1:DIGIT_W]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        prod_q  <= {{MC_W{1'b0}}, req_i.mplier};
        mcand_q <= req_i.mcand;
        cnt_q   <= CNT_W'(STEPS);
      end else if (cnt_q != '0) begin
        prod_q <= prod_d;
        cnt_q  <= cnt_q - 1'b1;
        done_q <= (cnt_q == CNT_W'(1));
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule
`default_nettype wire

// ===== design/cpid_checker.sv =====
// Port-level checker for the cascaded PID controller, bound to the top.
// Depends on cascade_pid_controller.
`timescale 1ns / 1ps
`default_nettype none
module cpid_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [63:0] m_axis_tdata
);

  // The block works on one item at a time: an accepted beat closes the input.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready stayed high after an accepted beat");

  // Ready only drops because a beat was taken.
  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(s_axis_tvalid))
    else $error("input ready fell without an accepted beat");

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output beat changed or dropped");

endmodule

bind cascade_pid_controller cpid_checker u_cpid_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for cascade_pid_controller. It drives random and
// directed control steps and clears, predicts drive and inner_setpoint in
// fixed point, and checks every output beat. Depends on cpid_pkg and the RTL.
`timescale 1ns / 1ps
module tb_top;
  import cpid_pkg::*;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] target;
    logic signed [31:0] outer_meas;
    logic signed [31:0] inner_meas;
  } step_item_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic signed [31:0] setpoint;
  } drive_out_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int LONG_HOLD      = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [95:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;

  step_item_t pending_items[$];
  drive_out_t expected_outputs[$];
  logic [23:0] gain_regs[8];
  logic signed [63:0] loop_integral[2];
  logic signed [63:0] loop_last_err[2];
  int  errors = 0;
  bit  quiet = 1'b0;
  bit  long_hold_req = 1'b0;
  bit  in_took = 1'b0;
  int  send_gap = 0;
  int  recv_stall = 0;
  int  idle_cycles = 0;

  always #2 clk_i = ~clk_i;

  cascade_pid_controller dut (
    .clk_i, .rst_ni,
    .s_axis_tdata, .s_axis_tuser, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tvalid, .m_axis_tready,
    .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  // sign(x) * ((|x| * g1 * g2) >> n), magnitude capped at 2^62.
  function automatic logic signed [63:0] scaled_term(logic signed [63:0] x,
      logic [23:0] g1, logic [23:0] g2, int n);
    logic neg;
    logic [127:0] mag;
    logic [127:0] prod;
    neg = x < 0;
    mag = neg ? 128'(-x) : 128'(x);
    prod = (mag * g1 * g2) >> n;
    if (prod > (128'd1 << 62)) prod = 128'd1 << 62;
    return neg ? -$signed(prod[63:0]) : $signed(prod[63:0]);
  endfunction

  // One PID stage; updates that stage's integrator and previous error.
  function automatic logic signed [31:0] run_stage(int s, logic signed [63:0] err,
      logic [23:0] kp, logic [23:0] ki, logic [23:0] kd);
    logic signed [63:0] p, inc, d, acc;
    logic signed [65:0] total;
    p = scaled_term(err, kp, 24'd1, 16);
    inc = scaled_term(err, ki, gain_regs[REG_STEP_PERIOD], 40);
    d = scaled_term(err - loop_last_err[s], kd, gain_regs[REG_STEP_RATE], 24);
    acc = loop_integral[s] + inc;
    if (acc > 64'sd140737488355327) acc = 64'sd140737488355327;
    if (acc < -64'sd140737488355328) acc = -64'sd140737488355328;
    loop_integral[s] = acc;
    loop_last_err[s] = err;
    total = 66'(p) + 66'(d) + 66'(acc);
    if (total > 66'sd2147483647) return 32'sh7fffffff;
    if (total < -66'sd2147483648) return 32'sh80000000;
    return total[31:0];
  endfunction

  function automatic drive_out_t predict_cascade(step_item_t it);
    drive_out_t r;
    if (it.kind == KIND_CLEAR) begin
      loop_integral = '{0, 0};
      loop_last_err = '{0, 0};
      return '0;
    end
    r.setpoint = run_stage(0, 64'(it.target) - 64'(it.outer_meas),
        gain_regs[REG_OUTER_KP], gain_regs[REG_OUTER_KI], gain_regs[REG_OUTER_KD]);
    r.drive = run_stage(1, 64'(r.setpoint) - 64'(it.inner_meas),
        gain_regs[REG_INNER_KP], gain_regs[REG_INNER_KI], gain_regs[REG_INNER_KD]);
    return r;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      2: return 32'($signed($urandom_range(0, 32'h1fffff)) - 32'sh100000);
      3: return 32'($signed($urandom_range(0, 32'h1ffffff)) - 32'sh1000000);
      default: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom())};
    endcase
  endfunction

  function automatic logic [23:0] pick_gain();
    case ($urandom_range(0, 3))
      0: return 24'($urandom());
      1: return 24'($urandom_range(0, 24'h3ffff));
      2: return 24'($urandom_range(0, 24'h1ffff));
      default: return $urandom_range(0, 1) ? 24'hffffff : 24'h0;
    endcase
  endfunction

  task automatic push_step(logic k, logic [31:0] t, logic [31:0] o, logic [31:0] i);
    step_item_t it;
    it.kind = k;
    it.target = t;
    it.outer_meas = o;
    it.inner_meas = i;
    pending_items.push_back(it);
  endtask

  task automatic push_random(int n);
    repeat (n) begin
      push_step($urandom_range(0, 15) == 0 ? KIND_CLEAR : KIND_STEP,
                pick_value(), pick_value(), pick_value());
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    gain_regs[idx] = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all(logic [23:0] kop, logic [23:0] koi, logic [23:0] kod,
      logic [23:0] kip, logic [23:0] kii, logic [23:0] kid,
      logic [23:0] per, logic [23:0] rate);
    write_reg(REG_OUTER_KP, kop);
    write_reg(REG_OUTER_KI, koi);
    write_reg(REG_OUTER_KD, kod);
    write_reg(REG_INNER_KP, kip);
    write_reg(REG_INNER_KI, kii);
    write_reg(REG_INNER_KD, kid);
    write_reg(REG_STEP_PERIOD, per);
    write_reg(REG_STEP_RATE, rate);
  endtask

  // Wait until every queued beat went through and the block is idle.
  task automatic wait_idle();
    while (pending_items.size() != 0 || expected_outputs.size() != 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  // Input side: accept bookkeeping and prediction at the rising edge.
  always @(posedge clk_i) begin
    in_took = s_axis_tvalid && s_axis_tready;
    if (in_took)
      expected_outputs.push_back(predict_cascade(step_item_t'({s_axis_tuser, s_axis_tdata[31:0],
          s_axis_tdata[63:32], s_axis_tdata[95:64]})));
  end

  // Input driver: next beat or an idle burst at the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_took)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        step_item_t it;
        it = pending_items.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= it.kind;
        s_axis_tdata <= {it.inner_meas, it.outer_meas, it.target};
        if (!quiet && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 15);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output ready: random stall bursts plus one long hold-off.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (long_hold_req) begin
        long_hold_req <= 1'b0;
        recv_stall <= LONG_HOLD;
        m_axis_tready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        recv_stall <= $urandom_range(0, 14);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Output monitor: compare each beat with the oldest prediction.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_outputs.size() == 0) begin
        $error("unexpected output beat %h", m_axis_tdata);
        errors++;
      end else begin
        drive_out_t e;
        e = expected_outputs.pop_front();
        if (m_axis_tdata[31:0] !== e.drive) begin
          $error("drive: expected %h, actual %h", e.drive, m_axis_tdata[31:0]);
          errors++;
        end
        if (m_axis_tdata[63:32] !== e.setpoint) begin
          $error("inner_setpoint: expected %h, actual %h", e.setpoint, m_axis_tdata[63:32]);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either stream.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    foreach (gain_regs[k]) gain_regs[k] = '0;
    loop_integral = '{0, 0};
    loop_last_err = '{0, 0};
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset gains: everything should come out zero.
    push_step(KIND_STEP, 32'h7fffffff, 32'h80000000, 32'h0);
    push_step(KIND_STEP, 32'h12345678, 32'h0, 32'h80000000);
    wait_idle();

    // Directed extremes with full gains and both time factors set.
    write_all(24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff,
              24'hffffff, 24'hffffff, 24'hffffff);
    push_step(KIND_STEP, 32'h7fffffff, 32'h80000000, 32'h80000000);
    push_step(KIND_STEP, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
    push_step(KIND_STEP, 32'h0, 32'h0, 32'h0);
    push_step(KIND_CLEAR, 32'hffffffff, 32'h1, 32'h55555555);
    push_step(KIND_STEP, 32'h00010000, 32'h0, 32'h0);
    wait_idle();
    write_all(24'h010000, 24'h008000, 24'h000400, 24'h020000, 24'h001000,
              24'h000100, 24'h000000, 24'h000000);
    push_step(KIND_STEP, 32'h00010000, 32'h0, 32'h00008000);
    push_step(KIND_STEP, 32'hffff0000, 32'h00020000, 32'h0);
    push_step(KIND_STEP, 32'h7fffffff, 32'h80000000, 32'h0);
    push_step(KIND_STEP, 32'h0, 32'h0, 32'h7fffffff);
    push_step(KIND_CLEAR, 32'h0, 32'h0, 32'h0);
    wait_idle();
    write_all(24'h010000, 24'h040000, 24'h000400, 24'h020000, 24'h010000,
              24'h000100, 24'h000418, 24'h00fa00);
    push_step(KIND_STEP, 32'h00010000, 32'h0, 32'h00008000);
    push_step(KIND_STEP, 32'h00030000, 32'h00010000, 32'hfffe0000);
    push_step(KIND_STEP, 32'h80000000, 32'h7fffffff, 32'h0);
    push_step(KIND_STEP, 32'hfffffff0, 32'h00000010, 32'h00000001);
    wait_idle();

    // Random phases, each with fresh register settings.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0)
        write_all(24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0);
      else if (ph == 1)
        write_all(24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff,
                  24'hffffff, 24'hffffff, 24'hffffff);
      else
        write_all(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                  pick_gain(), pick_gain(), pick_gain());
      if (ph == 3) long_hold_req = 1'b1;
      if (ph == 7) quiet = 1'b1;
      push_random(ph < 2 ? 120 : 200);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule
